[rtl/chmd_pkg.sv]
// ----------------------------------------------------------------------------
// chmd_pkg
// Shared types and constants for the chorus modulated delay block.
// ----------------------------------------------------------------------------
package chmd_pkg;

    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    localparam logic [19:0] BASE_DELAY_RST = 20'd122880;
    localparam logic [19:0] MOD_DEPTH_RST  = 20'd86016;
    localparam logic [8:0]  WET_MIX_RST    = 9'd102;
    localparam logic [8:0]  MIX_ONE        = 9'd256;

    typedef enum logic [1:0] {
        REG_ENABLE     = 2'd0,
        REG_BASE_DELAY = 2'd1,
        REG_MOD_DEPTH  = 2'd2,
        REG_WET_MIX    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic        enable;
        logic [19:0] base_delay;
        logic [19:0] mod_depth;
        logic [8:0]  wet_mix;
    } t_cfg;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_ring_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DLY,
        S_POS,
        S_RD1,
        S_RD2,
        S_ACC,
        S_WET,
        S_MIX
    } t_state;

endpackage

[rtl/chmd_regs.sv]
// ----------------------------------------------------------------------------
// chmd_regs
// APB configuration registers: enable, base delay, modulation depth, wet mix.
// ----------------------------------------------------------------------------
module chmd_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [chmd_pkg::APB_AW-1:0]  paddr,
    input  logic [chmd_pkg::APB_DW-1:0]  pwdata,
    output logic [chmd_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output chmd_pkg::t_cfg               o_cfg
);

    chmd_pkg::t_cfg     r_cfg;
    chmd_pkg::t_cfg     n_cfg;
    chmd_pkg::t_reg_idx w_idx;

    assign w_idx  = chmd_pkg::t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            unique case (w_idx)
                chmd_pkg::REG_ENABLE:     n_cfg.enable     = pwdata[0];
                chmd_pkg::REG_BASE_DELAY: n_cfg.base_delay = pwdata[19:0];
                chmd_pkg::REG_MOD_DEPTH:  n_cfg.mod_depth  = pwdata[19:0];
                chmd_pkg::REG_WET_MIX:    n_cfg.wet_mix    = pwdata[8:0];
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            chmd_pkg::REG_ENABLE:     prdata = chmd_pkg::APB_DW'(r_cfg.enable);
            chmd_pkg::REG_BASE_DELAY: prdata = chmd_pkg::APB_DW'(r_cfg.base_delay);
            chmd_pkg::REG_MOD_DEPTH:  prdata = chmd_pkg::APB_DW'(r_cfg.mod_depth);
            chmd_pkg::REG_WET_MIX:    prdata = chmd_pkg::APB_DW'(r_cfg.wet_mix);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable     <= 1'b0;
            r_cfg.base_delay <= chmd_pkg::BASE_DELAY_RST;
            r_cfg.mod_depth  <= chmd_pkg::MOD_DEPTH_RST;
            r_cfg.wet_mix    <= chmd_pkg::WET_MIX_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/chmd_ring.sv]
// ----------------------------------------------------------------------------
// chmd_ring
// Sample ring: single-port write at the write pointer, registered read.
// Entries not yet written since reset read as zero (tracked by fill state).
// ----------------------------------------------------------------------------
module chmd_ring #(
    parameter int unsigned RING_DEPTH = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  chmd_pkg::t_ring_ctl             i_ctl,
    input  logic signed [15:0]              i_wr_data,
    input  logic [$clog2(RING_DEPTH)-1:0]   i_rd_addr,
    output logic signed [15:0]              o_rd_data,
    output logic [$clog2(RING_DEPTH)-1:0]   o_wp
);

    localparam int unsigned AW = $clog2(RING_DEPTH);

    logic signed [15:0] mem [RING_DEPTH];
    logic [AW-1:0]      r_wp;
    logic               r_full;
    logic signed [15:0] r_rd_data;
    logic               r_rd_valid;

    assign o_wp      = r_wp;
    assign o_rd_data = r_rd_valid ? r_rd_data : 16'sd0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            mem[r_wp] <= i_wr_data;
        end
        if (i_ctl.rd) begin
            r_rd_data  <= mem[i_rd_addr];
            r_rd_valid <= r_full || (i_rd_addr < r_wp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_full <= 1'b0;
        end else if (i_ctl.wr) begin
            r_wp <= r_wp + 1'b1;
            if (r_wp == AW'(RING_DEPTH - 1)) begin
                r_full <= 1'b1;
            end
        end
    end

endmodule

[rtl/chorus_modulated_delay.sv]
// ----------------------------------------------------------------------------
// chorus_modulated_delay
// Chorus: LFO-modulated fractional delay with linear interpolation and
// dry/wet mix.
//
// Input channel (i_valid / o_stall) carries a dry sample and an LFO value;
// output channel (o_valid / i_stall) carries the mixed sample. One result
// per transfer, in order. Configuration via APB at 4*index.
// An enabled sample is written to the ring on transfer and steps through
// MUL, DLY, POS, RD1, RD2, ACC, WET and MIX; o_stall holds off the next
// transfer until the block is back in IDLE. The two ring reads through
// the single read port and the serial interpolation and mix multiplies
// set this pace. Bypassed samples go straight from IDLE to the mix step.
// The result sits in an output register; a stalled receiver holds it
// there. The block still takes the next sample and runs it up to the mix
// step, then waits there, with o_stall high, until the register is taken.
// Reset sets the registers to their defaults, clears the write pointer and
// marks the whole ring empty (reads as zero) with no clearing pass.
// RING_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module chorus_modulated_delay #(
    parameter int unsigned RING_DEPTH    = 4096,
    parameter int unsigned FRACTION_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [15:0]           i_audio_in,
    input  logic signed [15:0]           i_lfo_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [15:0]           o_audio_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [chmd_pkg::APB_AW-1:0]  paddr,
    input  logic [chmd_pkg::APB_DW-1:0]  pwdata,
    output logic [chmd_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    localparam int unsigned AW = $clog2(RING_DEPTH);
    localparam int unsigned F  = FRACTION_BITS;
    localparam int unsigned PW = AW + F;
    localparam int unsigned DW = (PW > 23) ? PW : 23;
    localparam int unsigned VW = F + 18;
    localparam int unsigned MW = 27;

    localparam logic signed [MW-1:0] SAT_MAX = MW'(32767);
    localparam logic signed [MW-1:0] SAT_MIN = -MW'(32768);

    chmd_pkg::t_cfg      w_cfg;
    chmd_pkg::t_ring_ctl w_ring_ctl;
    logic [AW-1:0]       w_wp;
    logic [AW-1:0]       w_rd_addr;
    logic signed [15:0]  w_rd_data;

    chmd_pkg::t_state    r_state;
    chmd_pkg::t_state    n_state;

    logic                w_in_xfer;
    logic                w_out_free;

    logic signed [15:0]  r_dry;
    logic [15:0]         r_lfo_ofs;
    logic                r_bypass;
    logic [AW-1:0]       r_wp;
    logic [35:0]         r_prod;
    logic signed [22:0]  r_delay;
    logic [PW-1:0]       r_pos;
    logic signed [VW-1:0] r_v;
    logic signed [15:0]  r_wet;
    logic signed [MW-1:0] r_y;
    logic                r_out_valid;
    logic signed [15:0]  r_out;

    logic [DW-1:0]       w_pos_full;
    logic [F-1:0]        w_frac;
    logic [F:0]          w_w1;
    logic signed [VW-1:0] w_v_adj;
    logic [8:0]          w_m;
    logic [8:0]          w_dm;
    logic signed [MW-1:0] w_sum;
    logic signed [MW-1:0] w_sum_adj;
    logic signed [MW-1:0] w_q;
    logic signed [15:0]  w_y;

    chmd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    chmd_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ring_ctl),
        .i_wr_data (i_audio_in),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .o_wp      (w_wp)
    );

    assign o_stall     = (r_state != chmd_pkg::S_IDLE);
    assign w_in_xfer   = i_valid && !o_stall;
    assign w_out_free  = !r_out_valid || !i_stall;
    assign o_valid     = r_out_valid;
    assign o_audio_out = r_out;

    // read position, modulo the ring in fixed point
    assign w_pos_full = (DW'(r_wp) << F) - DW'(r_delay);
    assign w_frac     = r_pos[F-1:0];
    assign w_w1       = {1'b1, {F{1'b0}}} - {1'b0, w_frac};
    assign w_rd_addr  = (r_state == chmd_pkg::S_RD1) ? r_pos[PW-1:F]
                                                     : r_pos[PW-1:F] + 1'b1;

    assign w_v_adj = r_v + (r_v[VW-1] ? $signed({{(VW-F){1'b0}}, {F{1'b1}}}) : '0);

    assign w_m       = (w_cfg.wet_mix > chmd_pkg::MIX_ONE) ? chmd_pkg::MIX_ONE
                                                           : w_cfg.wet_mix;
    assign w_dm      = chmd_pkg::MIX_ONE - w_m;
    assign w_sum     = r_y + MW'(r_wet) * MW'($signed({1'b0, w_m}));
    assign w_sum_adj = w_sum + (w_sum[MW-1] ? MW'(255) : '0);
    assign w_q       = w_sum_adj >>> 8;
    assign w_y       = (w_q > SAT_MAX) ? 16'sh7fff :
                       (w_q < SAT_MIN) ? 16'sh8000 : w_q[15:0];

    always_comb begin
        n_state       = r_state;
        w_ring_ctl.wr = 1'b0;
        w_ring_ctl.rd = 1'b0;
        unique case (r_state)
            chmd_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    w_ring_ctl.wr = w_cfg.enable;
                    n_state = w_cfg.enable ? chmd_pkg::S_MUL : chmd_pkg::S_MIX;
                end
            end
            chmd_pkg::S_MUL: n_state = chmd_pkg::S_DLY;
            chmd_pkg::S_DLY: n_state = chmd_pkg::S_POS;
            chmd_pkg::S_POS: n_state = chmd_pkg::S_RD1;
            chmd_pkg::S_RD1: begin
                w_ring_ctl.rd = 1'b1;
                n_state = chmd_pkg::S_RD2;
            end
            chmd_pkg::S_RD2: begin
                w_ring_ctl.rd = 1'b1;
                n_state = chmd_pkg::S_ACC;
            end
            chmd_pkg::S_ACC: n_state = chmd_pkg::S_WET;
            chmd_pkg::S_WET: n_state = chmd_pkg::S_MIX;
            chmd_pkg::S_MIX: begin
                if (w_out_free) begin
                    n_state = chmd_pkg::S_IDLE;
                end
            end
            default: n_state = chmd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chmd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_dry     <= i_audio_in;
            r_lfo_ofs <= {~i_lfo_value[15], i_lfo_value[14:0]};
            r_bypass  <= !w_cfg.enable;
            r_wp      <= w_wp;
        end
        case (r_state)
            chmd_pkg::S_MUL: r_prod <= 36'(r_lfo_ofs) * 36'(w_cfg.mod_depth);
            chmd_pkg::S_DLY: r_delay <= $signed({3'b0, w_cfg.base_delay})
                                      + $signed({2'b0, r_prod[35:15]})
                                      - $signed({3'b0, w_cfg.mod_depth});
            chmd_pkg::S_POS: r_pos <= w_pos_full[PW-1:0];
            chmd_pkg::S_RD2: r_v <= VW'(w_rd_data) * VW'($signed({1'b0, w_w1}));
            chmd_pkg::S_ACC: r_v <= r_v + VW'(w_rd_data)
                                        * VW'($signed({2'b0, w_frac}));
            chmd_pkg::S_WET: begin
                r_wet <= 16'(w_v_adj >>> F);
                r_y   <= MW'(r_dry) * MW'($signed({1'b0, w_dm}));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == chmd_pkg::S_MIX && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == chmd_pkg::S_MIX && w_out_free) begin
            r_out <= r_bypass ? r_dry : w_y;
        end
    end

    a_wr_only_on_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ring_ctl.wr |-> (w_in_xfer && w_cfg.enable))
        else $error("ring write outside an enabled input transfer");

    a_rd_only_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ring_ctl.rd |-> (r_state == chmd_pkg::S_RD1 || r_state == chmd_pkg::S_RD2))
        else $error("ring read issued outside read states");

    a_wp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && w_cfg.enable) |=> (w_wp == $past(w_wp) + 1'b1))
        else $error("write pointer did not advance after enabled sample");

    a_wp_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && !w_cfg.enable) |=> (w_wp == $past(w_wp)))
        else $error("write pointer moved on bypassed sample");

    a_wp_hold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != chmd_pkg::S_IDLE) |=> $stable(w_wp))
        else $error("write pointer moved while an item is in progress");

endmodule
